>>> hw/rtl/tct_pkg.sv
package tct_pkg;

  localparam int MAX_LINES   = 256;
  localparam int MAX_SAMPLES = 256;
  localparam int TIME_WIDTH  = 32;

  localparam int GRID_DEPTH = MAX_LINES * MAX_SAMPLES;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int CMP_W      = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int ROW_CAP    = (MAX_LINES < 256) ? MAX_LINES : 256;
  localparam int COL_CAP    = (MAX_SAMPLES < 256) ? MAX_SAMPLES : 256;

  localparam int COORD_W = 10;
  localparam int COUNT_W = 18;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_NEXT  = 2'd2;

  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_LINES     = 2'd1;
  localparam logic [1:0] REG_SAMPLES   = 2'd2;

  localparam logic [2:0] DIR_RESET = 3'd1;
  localparam logic [3:0] PROBE_COUNT = 4'd8;

  typedef struct packed {
    logic write;
    logic seed_scan;
    logic issue_scan;
    logic set_start;
    logic seed_probe;
    logic issue_probe;
    logic last_issue;
    logic take_step;
    logic load_out;
    logic out_last;
  } tct_cmd_t;

  typedef struct packed {
    logic eval_valid;
    logic eval_hit;
    logic eval_last;
    logic cur_is_start;
  } tct_sts_t;

  function automatic logic signed [COORD_W-1:0] step_row(input logic [2:0] dir);
    logic signed [COORD_W-1:0] s;
    case (dir)
      3'd1, 3'd2, 3'd3: s = 10'sd1;
      3'd5, 3'd6, 3'd7: s = -10'sd1;
      default:          s = 10'sd0;
    endcase
    return s;
  endfunction

  function automatic logic signed [COORD_W-1:0] step_col(input logic [2:0] dir);
    logic signed [COORD_W-1:0] s;
    case (dir)
      3'd0, 3'd1, 3'd7: s = 10'sd1;
      3'd3, 3'd4, 3'd5: s = -10'sd1;
      default:          s = 10'sd0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] probe_first(input logic [2:0] prev);
    return prev[0] ? prev + 3'd2 : prev + 3'd1;
  endfunction

endpackage

>>> hw/rtl/tct_ctrl.sv
module tct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        mode,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tct_pkg::tct_sts_t sts,
  output tct_pkg::tct_cmd_t cmd
);
  import tct_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PSEED = 5'b00100,
    S_PROBE = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic       tracing, tracing_next;
  logic       is_start, is_start_next;
  logic       scan_any, scan_any_next;
  logic       any, any_next;
  logic [3:0] issue_cnt, issue_cnt_next;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    tracing_next   = tracing;
    is_start_next  = is_start;
    scan_any_next  = scan_any;
    any_next       = any;
    issue_cnt_next = issue_cnt;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_LOAD: cmd.write = 1'b1;
            MODE_START: begin
              tracing_next  = 1'b0;
              scan_any_next = 1'b0;
              cmd.seed_scan = 1'b1;
              state_next    = S_SCAN;
            end
            MODE_NEXT: begin
              if (tracing) begin
                cmd.seed_probe = 1'b1;
                is_start_next  = 1'b0;
                issue_cnt_next = '0;
                state_next     = S_PROBE;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.issue_scan = 1'b1;
        if (sts.eval_valid) begin
          if (sts.eval_hit) begin
            scan_any_next = 1'b1;
          end else if (!scan_any) begin
            state_next = S_IDLE;
          end else begin
            cmd.set_start = 1'b1;
            state_next    = S_PSEED;
          end
        end
      end
      S_PSEED: begin
        cmd.seed_probe = 1'b1;
        is_start_next  = 1'b1;
        issue_cnt_next = '0;
        state_next     = S_PROBE;
      end
      S_PROBE: begin
        cmd.issue_probe = (issue_cnt != PROBE_COUNT);
        cmd.last_issue  = (issue_cnt == PROBE_COUNT - 4'd1);
        if (cmd.issue_probe) issue_cnt_next = issue_cnt + 4'd1;
        if (sts.eval_valid) begin
          if (sts.eval_hit) begin
            if (is_start) any_next = 1'b1;
            else cmd.take_step = 1'b1;
            state_next = S_EMIT;
          end else if (sts.eval_last) begin
            if (is_start) begin
              any_next   = 1'b0;
              state_next = S_EMIT;
            end else begin
              tracing_next = 1'b0;
              state_next   = S_IDLE;
            end
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_last = is_start ? !any : sts.cur_is_start;
          tracing_next = is_start ? any : !sts.cur_is_start;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tracing   <= 1'b0;
      is_start  <= 1'b0;
      scan_any  <= 1'b0;
      any       <= 1'b0;
      issue_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      tracing   <= tracing_next;
      is_start  <= is_start_next;
      scan_any  <= scan_any_next;
      any       <= any_next;
      issue_cnt <= issue_cnt_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/tct_datapath.sv
module tct_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  tct_pkg::tct_cmd_t            cmd,
  input  logic [7:0]                   row,
  input  logic [7:0]                   column,
  input  logic [31:0]                  time_value,
  input  logic [31:0]                  time_threshold,
  input  logic [8:0]                   lines_in_use,
  input  logic [8:0]                   samples_in_use,
  output tct_pkg::tct_sts_t            sts,
  output logic [7:0]                   point_row,
  output logic [7:0]                   point_column,
  output logic [tct_pkg::COUNT_W-1:0]  point_number,
  output logic                         last_point
);
  import tct_pkg::*;

  logic [TIME_WIDTH-1:0] grid [GRID_DEPTH];
  logic [TIME_WIDTH-1:0] mem_q;

  logic [7:0]                scan_r;
  logic signed [COORD_W-1:0] scan_c;
  logic [7:0]                base_r, base_c;
  logic [2:0]                probe_dir;
  logic [7:0]                cur_r, cur_c, start_r, start_c;
  logic [2:0]                prev_dir;
  logic [COUNT_W-1:0]        count;

  logic                      q_valid, q_inrange, q_last;
  logic signed [COORD_W-1:0] q_r, q_c;
  logic [2:0]                q_dir;

  logic                      issue;
  logic signed [COORD_W-1:0] ir, ic, left_c;
  logic [8:0]                lim_r, lim_c;
  logic                      in_range, store_ok;
  logic [ADDR_W-1:0]         raddr, waddr;

  assign lim_r = (int'(lines_in_use) > ROW_CAP) ? 9'(ROW_CAP) : lines_in_use;
  assign lim_c = (int'(samples_in_use) > COL_CAP) ? 9'(COL_CAP) : samples_in_use;
  assign issue = cmd.issue_scan || cmd.issue_probe;

  always_comb begin
    if (cmd.issue_scan) begin
      ir = signed'({2'b00, scan_r});
      ic = scan_c;
    end else begin
      ir = signed'({2'b00, base_r}) + step_row(probe_dir);
      ic = signed'({2'b00, base_c}) + step_col(probe_dir);
    end
  end

  assign in_range = (ir >= 0) && (ir < signed'({1'b0, lim_r}))
                 && (ic >= 0) && (ic < signed'({1'b0, lim_c}));
  assign raddr = ADDR_W'(ADDR_W'(ir[7:0]) * ADDR_W'(MAX_SAMPLES) + ADDR_W'(ic[7:0]));
  assign waddr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_SAMPLES) + ADDR_W'(column));
  assign store_ok = (int'(row) < MAX_LINES) && (int'(column) < MAX_SAMPLES);
  assign left_c = q_c + 10'sd1;

  always_ff @(posedge clk) begin
    if (cmd.write && store_ok) grid[waddr] <= TIME_WIDTH'(time_value);
  end

  always_ff @(posedge clk) begin
    if (issue) mem_q <= grid[raddr];
  end

  assign sts.eval_valid   = q_valid;
  assign sts.eval_hit     = q_inrange && (CMP_W'(mem_q) <= CMP_W'(time_threshold));
  assign sts.eval_last    = q_last;
  assign sts.cur_is_start = (cur_r == start_r) && (cur_c == start_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid  <= 1'b0;
      cur_r    <= '0;
      cur_c    <= '0;
      start_r  <= '0;
      start_c  <= '0;
      prev_dir <= DIR_RESET;
      count    <= '0;
    end else begin
      q_valid <= issue;
      if (cmd.set_start) begin
        cur_r    <= q_r[7:0];
        cur_c    <= left_c[7:0];
        start_r  <= q_r[7:0];
        start_c  <= left_c[7:0];
        prev_dir <= DIR_RESET;
        count    <= '0;
      end else if (cmd.take_step) begin
        cur_r    <= q_r[7:0];
        cur_c    <= q_c[7:0];
        prev_dir <= q_dir;
        if (count != COUNT_MAX) count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      q_r       <= ir;
      q_c       <= ic;
      q_dir     <= probe_dir;
      q_inrange <= in_range;
      q_last    <= cmd.last_issue;
    end
    if (cmd.seed_scan) begin
      scan_r <= row;
      scan_c <= signed'({2'b00, column});
    end else if (cmd.issue_scan) begin
      scan_c <= scan_c - 10'sd1;
    end
    if (cmd.seed_probe) begin
      base_r    <= cur_r;
      base_c    <= cur_c;
      probe_dir <= probe_first(prev_dir);
    end else if (cmd.issue_probe) begin
      probe_dir <= probe_dir - 3'd1;
    end
    if (cmd.load_out) begin
      point_row    <= cur_r;
      point_column <= cur_c;
      point_number <= count;
      last_point   <= cmd.out_last;
    end
  end

endmodule

>>> hw/rtl/threshold_contour_tracer.sv
// Load item: the grid write happens at the accepting edge.
// Next item: one grid read per cycle probes up to eight neighbors.
// Start item: the scan walks left over the inside cells, then the neighbors are
// probed, again one grid read per cycle.
// Reset clears the trace state and sets the size registers to 256 and the
// threshold to 0; the grid memory keeps its contents and is not cleared.
module threshold_contour_tracer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tct_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic [7:0]                   row,
  input  logic [7:0]                   column,
  input  logic [31:0]                  time_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   point_row,
  output logic [7:0]                   point_column,
  output logic [tct_pkg::COUNT_W-1:0]  point_number,
  output logic                         last_point
);
  import tct_pkg::*;

  logic [31:0] time_threshold;
  logic [8:0]  lines_in_use;
  logic [8:0]  samples_in_use;
  logic        cfg_write;
  logic [1:0]  reg_index;
  tct_cmd_t    cmd;
  tct_sts_t    sts;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      time_threshold <= '0;
      lines_in_use   <= 9'd256;
      samples_in_use <= 9'd256;
    end else if (cfg_write) begin
      case (reg_index)
        REG_THRESHOLD: time_threshold <= pwdata;
        REG_LINES:     lines_in_use   <= pwdata[8:0];
        REG_SAMPLES:   samples_in_use <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_THRESHOLD: prdata = time_threshold;
      REG_LINES:     prdata = {23'd0, lines_in_use};
      REG_SAMPLES:   prdata = {23'd0, samples_in_use};
      default:       prdata = '0;
    endcase
  end

  tct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tct_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .row            (row),
    .column         (column),
    .time_value     (time_value),
    .time_threshold (time_threshold),
    .lines_in_use   (lines_in_use),
    .samples_in_use (samples_in_use),
    .sts            (sts),
    .point_row      (point_row),
    .point_column   (point_column),
    .point_number   (point_number),
    .last_point     (last_point)
  );

  a_one_read_source: assert property (@(posedge clk) disable iff (rst)
    !(cmd.issue_scan && cmd.issue_probe))
    else $error("scan and probe read the grid in the same cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled result");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !(cmd.issue_scan || cmd.issue_probe || cmd.take_step))
    else $error("item accepted while a trace step is in progress");

  a_emit_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> !in_stall)
    else $error("block not ready after loading a result");

endmodule

>>> dv/threshold_contour_tracer_test.sv
`timescale 1ns / 1ps

module threshold_contour_tracer_test;
  import tct_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned ITEM_TARGET = 1350;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [7:0]         pt_row;
    logic [7:0]         pt_col;
    logic [COUNT_W-1:0] number;
    logic               closing;
  } boundary_point_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          mode = MODE_LOAD;
  logic [7:0]          row = '0;
  logic [7:0]          column = '0;
  logic [31:0]         time_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          point_row;
  logic [7:0]          point_column;
  logic [COUNT_W-1:0]  point_number;
  logic                last_point;

  threshold_contour_tracer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .row(row), .column(column), .time_value(time_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_row(point_row), .point_column(point_column),
    .point_number(point_number), .last_point(last_point)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [31:0]        arrival_grid [GRID_DEPTH];
  logic [31:0]        cfg_threshold = '0;
  int                 cfg_lines = 256;
  int                 cfg_samples = 256;
  int                 trace_row = 0;
  int                 trace_col = 0;
  int                 origin_row = 0;
  int                 origin_col = 0;
  logic [2:0]         heading = DIR_RESET;
  logic [COUNT_W-1:0] chain_count = '0;
  bit                 tracing = 1'b0;
  int                 row_step [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
  int                 col_step [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

  boundary_point_t    expected_points [$];
  int unsigned        errors = 0;
  int unsigned        items_sent = 0;
  int unsigned        burst_left = 0;
  int unsigned        stall_run = 0;
  int unsigned        stall_pct = 0;

  // written region of the current field; its guard ring stays outside
  int                 rect_r0 = 0;
  int                 rect_r1 = 0;
  int                 rect_c0 = 0;
  int                 rect_c1 = 0;

  function automatic bit cell_inside(input int r, input int c);
    if (r < 0 || c < 0) return 1'b0;
    if (r >= cfg_lines || r >= ROW_CAP) return 1'b0;
    if (c >= cfg_samples || c >= COL_CAP) return 1'b0;
    return arrival_grid[r * MAX_SAMPLES + c] <= cfg_threshold;
  endfunction

  function automatic void predict_item(input logic [1:0] m, input logic [7:0] r_in,
                                       input logic [7:0] c_in, input logic [31:0] t);
    int r;
    int c;
    int k;
    int nr;
    int nc;
    logic [2:0] d;
    bit any;
    bit found;
    bit closing;
    r = r_in;
    c = c_in;
    case (m)
      MODE_LOAD: arrival_grid[r * MAX_SAMPLES + c] = t;
      MODE_START: begin
        tracing = 1'b0;
        if (cell_inside(r, c)) begin
          while (cell_inside(r, c - 1)) c--;
          origin_row = r;
          origin_col = c;
          trace_row = r;
          trace_col = c;
          heading = DIR_RESET;
          chain_count = '0;
          any = 1'b0;
          for (k = 0; k < 8; k++) any |= cell_inside(r + row_step[k], c + col_step[k]);
          tracing = any;
          expected_points.push_back('{8'(r), 8'(c), chain_count, !any});
        end
      end
      MODE_NEXT: begin
        if (tracing) begin
          d = heading[0] ? heading + 3'd2 : heading + 3'd1;
          found = 1'b0;
          for (k = 0; k < 8; k++) begin
            if (!found) begin
              nr = trace_row + row_step[d];
              nc = trace_col + col_step[d];
              if (cell_inside(nr, nc)) begin
                found = 1'b1;
                trace_row = nr;
                trace_col = nc;
                heading = d;
                if (chain_count != COUNT_MAX) chain_count++;
                closing = (trace_row == origin_row && trace_col == origin_col);
                if (closing) tracing = 1'b0;
                expected_points.push_back('{8'(nr), 8'(nc), chain_count, closing});
              end else begin
                d = d - 3'd1;
              end
            end
          end
          if (!found) tracing = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : collect
    boundary_point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point expected none actual row %0d column %0d number %0d last %0b",
                 $time, point_row, point_column, point_number, last_point);
        errors++;
      end else begin
        want = expected_points.pop_front();
        check_field("point_row", want.pt_row, point_row);
        check_field("point_column", want.pt_col, point_column);
        check_field("point_number", want.number, point_number);
        check_field("last_point", want.closing, last_point);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_run == 0) begin
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 50;
        default: stall_pct = 80;
      endcase
      stall_run = $urandom_range(200, 20);
    end
    stall_run--;
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("** threshold_contour_tracer: FAILED **");
    $finish;
  end

  task automatic send_item(input logic [1:0] m, input logic [7:0] r, input logic [7:0] c,
                           input logic [31:0] t);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    row <= r;
    column <= c;
    time_value <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (m == MODE_LOAD || m == MODE_START || (m == MODE_NEXT && tracing)) items_sent++;
    predict_item(m, r, c, t);
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %0d expected %0h actual %0h", $time, idx, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_THRESHOLD: cfg_threshold = value;
      REG_LINES: cfg_lines = value[8:0];
      REG_SAMPLES: cfg_samples = value[8:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_reg(idx, (idx == REG_THRESHOLD) ? value : {23'd0, value[8:0]});
  endtask

  function automatic bit is_guard(input int r, input int c);
    if (r < rect_r0 || r > rect_r1 || c < rect_c0 || c > rect_c1) return 1'b0;
    return (r == rect_r0 && rect_r0 > 0) || (r == rect_r1 && rect_r1 < cfg_lines - 1) ||
           (c == rect_c0 && rect_c0 > 0) || (c == rect_c1 && rect_c1 < cfg_samples - 1);
  endfunction

  function automatic logic [31:0] pick_time(input bit want_inside);
    if (want_inside || cfg_threshold == 32'hFFFF_FFFF) begin
      case ($urandom_range(3, 0))
        0: return cfg_threshold;
        1: return 32'd0;
        default: return $urandom_range(cfg_threshold, 0);
      endcase
    end
    case ($urandom_range(3, 0))
      0: return cfg_threshold + 32'd1;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'hFFFF_FFFF, cfg_threshold + 32'd1);
    endcase
  endfunction

  function automatic logic [31:0] pick_threshold();
    return ($urandom_range(7, 0) == 0) ? 32'hFFFF_FFFF : $urandom;
  endfunction

  task automatic lay_field(input int lines, input int samples, input logic [31:0] thr,
                           input int r0, input int r1, input int c0, input int c1,
                           input int unsigned inside_pct);
    int r;
    int c;
    quiesce();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_LINES, lines);
    write_reg(REG_SAMPLES, samples);
    rect_r0 = r0;
    rect_r1 = r1;
    rect_c0 = c0;
    rect_c1 = c1;
    for (r = r0; r <= r1; r++)
      for (c = c0; c <= c1; c++)
        send_item(MODE_LOAD, 8'(r), 8'(c),
                  pick_time(!is_guard(r, c) && $urandom_range(99, 0) < inside_pct));
  endtask

  task automatic random_load();
    logic [7:0] r;
    logic [7:0] c;
    r = 8'($urandom);
    c = 8'($urandom);
    if (r >= rect_r0 && r <= rect_r1 && c >= rect_c0 && c <= rect_c1)
      send_item(MODE_LOAD, r, c, pick_time(!is_guard(r, c) && $urandom_range(1, 0) == 1));
    else
      send_item(MODE_LOAD, r, c, $urandom);
  endtask

  function automatic void choose_start(output logic [7:0] r, output logic [7:0] c);
    int unsigned tries;
    if ($urandom_range(9, 0) == 0 && cfg_lines < 256) begin
      r = 8'($urandom_range(255, cfg_lines));
      c = 8'($urandom);
      return;
    end
    if ($urandom_range(9, 0) == 0 && cfg_samples < 256) begin
      r = 8'($urandom);
      c = 8'($urandom_range(255, cfg_samples));
      return;
    end
    tries = 0;
    do begin
      r = 8'($urandom_range(rect_r1, rect_r0));
      c = 8'($urandom_range(rect_c1, rect_c0));
      tries++;
    end while (!cell_inside(r, c) && tries < 6);
  endfunction

  task automatic run_traces(input int unsigned attempts, input int unsigned cap);
    int unsigned steps;
    int unsigned pick;
    logic [7:0] r;
    logic [7:0] c;
    repeat (attempts) begin
      choose_start(r, c);
      send_item(MODE_START, r, c, $urandom);
      steps = 0;
      while (tracing && steps < cap) begin
        pick = $urandom_range(99, 0);
        if (pick < 88) send_item(MODE_NEXT, 8'($urandom), 8'($urandom), $urandom);
        else if (pick < 95) random_load();
        else if (pick < 98) send_item(MODE_UNUSED, 8'($urandom), 8'($urandom), $urandom);
        else steps = cap;
        steps++;
      end
      if ($urandom_range(3, 0) == 0) send_item(MODE_NEXT, 8'($urandom), 8'($urandom), $urandom);
    end
  endtask

  task automatic test_register_access();
    check_reg(REG_THRESHOLD, 32'd0);
    check_reg(REG_LINES, 32'd256);
    check_reg(REG_SAMPLES, 32'd256);
    write_reg(REG_THRESHOLD, 32'hA5A5_5A5A);
    write_reg(REG_LINES, 32'd256);
    write_reg(REG_SAMPLES, 32'd1);
  endtask

  task automatic test_directed_cases();
    quiesce();
    write_reg(REG_THRESHOLD, 32'd100);
    write_reg(REG_LINES, 32'd2);
    write_reg(REG_SAMPLES, 32'd3);
    rect_r0 = 0;
    rect_r1 = 1;
    rect_c0 = 0;
    rect_c1 = 2;
    send_item(MODE_LOAD, 8'd0, 8'd0, 32'd0);
    send_item(MODE_LOAD, 8'd0, 8'd1, 32'd100);
    send_item(MODE_LOAD, 8'd0, 8'd2, 32'd101);
    send_item(MODE_LOAD, 8'd1, 8'd0, 32'hFFFF_FFFF);
    send_item(MODE_LOAD, 8'd1, 8'd1, 32'd50);
    send_item(MODE_LOAD, 8'd1, 8'd2, 32'd200);
    send_item(MODE_LOAD, 8'd255, 8'd255, 32'hFFFF_FFFF);
    send_item(MODE_NEXT, 8'd0, 8'd0, 32'd0);
    send_item(MODE_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(MODE_START, 8'd1, 8'd2, 32'd0);
    send_item(MODE_START, 8'd255, 8'd255, 32'd0);
    // walk left to the row's first inside cell, then close the loop
    send_item(MODE_START, 8'd0, 8'd1, 32'd0);
    repeat (4) send_item(MODE_NEXT, 8'd0, 8'd0, 32'd0);
    // isolate the start cell
    send_item(MODE_LOAD, 8'd1, 8'd1, 32'd101);
    send_item(MODE_LOAD, 8'd0, 8'd1, 32'd101);
    send_item(MODE_START, 8'd0, 8'd0, 32'd0);
    // restart mid-trace, then strand the trace
    send_item(MODE_LOAD, 8'd0, 8'd1, 32'd100);
    send_item(MODE_START, 8'd0, 8'd0, 32'd0);
    send_item(MODE_START, 8'd0, 8'd1, 32'd0);
    send_item(MODE_LOAD, 8'd0, 8'd1, 32'hFFFF_FFFF);
    send_item(MODE_NEXT, 8'd0, 8'd0, 32'd0);
    send_item(MODE_NEXT, 8'd0, 8'd0, 32'd0);
  endtask

  task automatic test_size_extremes();
    lay_field(1, 9, $urandom_range(32'hFFFF_FFFE, 0), 0, 0, 0, 8, 80);
    run_traces(6, 40);
    lay_field(9, 1, $urandom_range(32'hFFFF_FFFE, 0), 0, 8, 0, 0, 80);
    run_traces(6, 40);
    lay_field(1, 1, $urandom_range(32'hFFFF_FFFE, 0), 0, 0, 0, 0, 100);
    run_traces(3, 5);
    lay_field(256, 256, $urandom_range(32'hFFFF_FFFE, 0), 248, 255, 248, 255, 75);
    run_traces(8, 60);
    lay_field(256, 6, $urandom_range(32'hFFFF_FFFE, 0), 0, 7, 0, 5, 70);
    run_traces(6, 40);
    lay_field(1, 256, $urandom_range(32'hFFFF_FFFE, 0), 0, 0, 0, 255, 95);
    run_traces(4, 40);
  endtask

  task automatic test_threshold_extremes();
    lay_field(5, 6, 32'd0, 0, 4, 0, 5, 60);
    run_traces(6, 40);
    lay_field(6, 5, 32'hFFFF_FFFF, 0, 5, 0, 4, 100);
    run_traces(4, 40);
    lay_field(4, 7, 32'hFFFF_FFFE, 0, 3, 0, 6, 60);
    run_traces(6, 40);
  endtask

  task automatic test_random_fields();
    int lines;
    int samples;
    int r0;
    int c0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(3, 0) == 0) begin
        lines = $urandom_range(256, 8);
        samples = $urandom_range(256, 8);
        r0 = $urandom_range(lines - 6, 0);
        c0 = $urandom_range(samples - 6, 0);
        lay_field(lines, samples, $urandom_range(32'hFFFF_FFFE, 0), r0, r0 + 5, c0, c0 + 5,
                  $urandom_range(85, 50));
      end else begin
        lines = $urandom_range(10, 2);
        samples = $urandom_range(10, 2);
        lay_field(lines, samples, pick_threshold(), 0, lines - 1, 0, samples - 1,
                  $urandom_range(90, 45));
      end
      run_traces($urandom_range(10, 4), 40);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_register_access();
    test_directed_cases();
    test_size_extremes();
    test_threshold_extremes();
    test_random_fields();
    quiesce();
    if (errors == 0) $display("** threshold_contour_tracer: PASSED **");
    else $display("** threshold_contour_tracer: FAILED **");
    $finish;
  end

endmodule
